// ===== design/bsp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the Bezier surface point evaluator.
package bsp_pkg;

    // Grid size and field widths
    localparam int GRID_ROWS = 4;
    localparam int GRID_COLS = 4;
    localparam int NPTS      = GRID_ROWS * GRID_COLS;
    localparam int IDX_W     = $clog2(NPTS);
    localparam int ROW_W     = 2;
    localparam int COL_W     = 2;
    localparam int COORD_W   = 32;
    localparam int PAR_W     = 17;
    localparam int FRAC_W    = 16;
    localparam int HALF      = 1 << (FRAC_W - 1);

    localparam logic [PAR_W-1:0] Q_ONE = 17'h1_0000;

    // Bernstein degrees per axis
    localparam int DEG_U   = GRID_ROWS - 1;
    localparam int DEG_V   = GRID_COLS - 1;
    localparam int MAX_DEG = (DEG_U > DEG_V) ? DEG_U : DEG_V;
    localparam int K_W     = $clog2(MAX_DEG + 1);
    localparam int BIN_W   = MAX_DEG;

    // Datapath widths
    localparam int MAC_LAT = 3;
    localparam int CNT_MAX = (MAX_DEG > MAC_LAT) ? MAX_DEG : MAC_LAT;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);
    localparam int PROD_W  = COORD_W + PAR_W + 1;
    localparam int ACC_W   = PROD_W + IDX_W + 1;

    typedef logic [K_W-1:0]            t_kidx;
    typedef logic [BIN_W-1:0]          t_binom;
    typedef t_binom [MAX_DEG:0]        t_binom_row;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_EVAL = 1'b1
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POW,
        ST_PROD,
        ST_MAC,
        ST_DRAIN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_point;

    // Basis unit control
    typedef struct packed {
        logic  init;
        logic  pow_en;
        t_kidx pow_k;
        logic  prod_en;
        t_kidx prod_k;
    } t_bas_ctl;

    // Accumulator control
    typedef struct packed {
        logic             clear;
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
    } t_mac_ctl;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      ovf;
    } t_result;

    // Row n of Pascal's triangle, built by additions only
    function automatic t_binom_row binom_row(input int n);
        int         c [0:MAX_DEG];
        t_binom_row r;
        for (int i = 0; i <= MAX_DEG; i++) begin
            c[i] = (i == 0) ? 1 : 0;
        end
        for (int row = 1; row <= MAX_DEG; row++) begin
            if (row <= n) begin
                for (int k = MAX_DEG; k >= 1; k--) begin
                    c[k] = c[k] + c[k-1];
                end
            end
        end
        for (int i = 0; i <= MAX_DEG; i++) begin
            r[i] = BIN_W'(c[i]);
        end
        return r;
    endfunction

    // Product of two Q1.16 values up to 1.0, rounded back to Q1.16
    function automatic logic [PAR_W-1:0] q_round(input logic [2*PAR_W-1:0] p);
        logic [2*PAR_W-1:0] s;
        s = p + (2*PAR_W)'(HALF);
        return s[FRAC_W+PAR_W-1:FRAC_W];
    endfunction

endpackage

// ===== design/bsp_in_if.sv =====
`timescale 1ns / 1ps
// Input channel: control point loads and evaluate requests.
interface bsp_in_if;
    import bsp_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      action;
    logic [ROW_W-1:0]          point_row;
    logic [COL_W-1:0]          point_col;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [PAR_W-1:0]          u_param;
    logic [PAR_W-1:0]          v_param;

    modport source (
        output valid, action, point_row, point_col, coord_x, coord_y, coord_z,
               u_param, v_param,
        input  ready
    );

    modport sink (
        input  valid, action, point_row, point_col, coord_x, coord_y, coord_z,
               u_param, v_param,
        output ready
    );
endinterface

// ===== design/bsp_out_if.sv =====
`timescale 1ns / 1ps
// Output channel: evaluated surface points.
interface bsp_out_if;
    import bsp_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] surf_x;
    logic signed [COORD_W-1:0] surf_y;
    logic signed [COORD_W-1:0] surf_z;
    logic                      overflow;

    modport source (
        output valid, surf_x, surf_y, surf_z, overflow,
        input  ready
    );

    modport sink (
        input  valid, surf_x, surf_y, surf_z, overflow,
        output ready
    );
endinterface

// ===== design/bsp_basis.sv =====
`timescale 1ns / 1ps
// Bernstein basis unit: powers of t and 1-t, then binomial-weighted products.
module bsp_basis (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bsp_pkg::t_bas_ctl                i_ctl,
    input  logic [1:0][bsp_pkg::PAR_W-1:0]   i_par,
    input  logic [1:0][bsp_pkg::K_W-1:0]     i_sel,
    output logic [1:0][bsp_pkg::PAR_W-1:0]   o_basis
);
    import bsp_pkg::*;

    // Lane 0 is the u axis (rows), lane 1 the v axis (columns)
    for (genvar l = 0; l < 2; l++) begin : g_lane
        localparam int         DEG   = (l == 0) ? DEG_U : DEG_V;
        localparam t_binom_row C_TAB = binom_row(DEG);
        localparam t_kidx      DEG_K = K_W'(DEG);

        logic [PAR_W-1:0]         r_t;
        logic [PAR_W-1:0]         r_s;
        logic [PAR_W-1:0]         r_prun;
        logic [PAR_W-1:0]         r_srun;
        logic [PAR_W-1:0]         r_pt [0:MAX_DEG];
        logic [PAR_W-1:0]         r_ps [0:MAX_DEG];
        logic [PAR_W-1:0]         r_b  [0:MAX_DEG];
        logic [2*PAR_W-1:0]       r_m;
        t_kidx                    r_mk;
        logic                     r_mv;
        logic [2*PAR_W-1:0]       pt_mul;
        logic [2*PAR_W-1:0]       ps_mul;
        t_kidx                    s_idx;
        logic [2*PAR_W+BIN_W-1:0] bprod;
        logic [2*PAR_W+BIN_W-1:0] bsum;

        // Power step and basis rounding
        always_comb begin
            pt_mul = {{PAR_W{1'b0}}, r_prun} * {{PAR_W{1'b0}}, r_t};
            ps_mul = {{PAR_W{1'b0}}, r_srun} * {{PAR_W{1'b0}}, r_s};
            s_idx  = (i_ctl.prod_k > DEG_K) ? '0 : t_kidx'(DEG_K - i_ctl.prod_k);
            bprod  = (2*PAR_W+BIN_W)'(r_m) * (2*PAR_W+BIN_W)'(C_TAB[r_mk]);
            bsum   = bprod + (2*PAR_W+BIN_W)'(HALF);
        end

        // Power tables, running powers, product stage and basis values
        always_ff @(posedge i_clk) begin
            if (i_ctl.init) begin
                r_t     <= i_par[l];
                r_s     <= Q_ONE - i_par[l];
                r_prun  <= Q_ONE;
                r_srun  <= Q_ONE;
                r_pt[0] <= Q_ONE;
                r_ps[0] <= Q_ONE;
            end else if (i_ctl.pow_en) begin
                r_prun             <= q_round(pt_mul);
                r_srun             <= q_round(ps_mul);
                r_pt[i_ctl.pow_k]  <= q_round(pt_mul);
                r_ps[i_ctl.pow_k]  <= q_round(ps_mul);
            end
            if (i_ctl.prod_en) begin
                r_m  <= {{PAR_W{1'b0}}, r_pt[i_ctl.prod_k]} *
                        {{PAR_W{1'b0}}, r_ps[s_idx]};
                r_mk <= i_ctl.prod_k;
            end
            if (r_mv) begin
                r_b[r_mk] <= bsum[FRAC_W+PAR_W-1:FRAC_W];
            end
        end

        // Product stage valid
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_mv <= 1'b0;
            end else begin
                r_mv <= i_ctl.prod_en;
            end
        end

        assign o_basis[l] = r_b[i_sel[l]];
    end

endmodule

// ===== design/bsp_mac.sv =====
`timescale 1ns / 1ps
// Control point store and the shared weight / multiply-accumulate pipeline.
module bsp_mac (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wr_en,
    input  logic [bsp_pkg::IDX_W-1:0] i_wr_idx,
    input  bsp_pkg::t_point           i_wr_pt,
    input  bsp_pkg::t_mac_ctl         i_ctl,
    input  logic [bsp_pkg::PAR_W-1:0] i_bu,
    input  logic [bsp_pkg::PAR_W-1:0] i_bv,
    output bsp_pkg::t_result          o_res
);
    import bsp_pkg::*;

    t_point                     r_mem [0:NPTS-1];
    t_point                     r_rd;
    t_point                     r_pt;
    logic [2*PAR_W-1:0]         r_wprod;
    logic [PAR_W-1:0]           r_w;
    logic signed [PAR_W:0]      w_s;
    logic signed [PROD_W-1:0]   r_px;
    logic signed [PROD_W-1:0]   r_py;
    logic signed [PROD_W-1:0]   r_pz;
    logic signed [ACC_W-1:0]    r_ax;
    logic signed [ACC_W-1:0]    r_ay;
    logic signed [ACC_W-1:0]    r_az;
    logic                       r_v1;
    logic                       r_v2;
    logic                       r_v3;
    logic [COORD_W:0]           sx;
    logic [COORD_W:0]           sy;
    logic [COORD_W:0]           sz;

    // Round to Q16.16 and saturate; top bit flags saturation
    function automatic logic [COORD_W:0] round_sat(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W:0]        b;
        logic signed [ACC_W-FRAC_W:0] r;
        logic                         hi_ones;
        logic                         hi_zeros;
        b        = (ACC_W+1)'(a) + (ACC_W+1)'(HALF);
        r        = b[ACC_W:FRAC_W];
        hi_ones  = &r[ACC_W-FRAC_W:COORD_W-1];
        hi_zeros = ~|r[ACC_W-FRAC_W:COORD_W-1];
        if (hi_ones || hi_zeros) begin
            return {1'b0, r[COORD_W-1:0]};
        end else if (r[ACC_W-FRAC_W]) begin
            return {1'b1, 1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            return {1'b1, 1'b0, {(COORD_W-1){1'b1}}};
        end
    endfunction

    // Store: one write port for loads, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_pt;
        end
        if (i_ctl.rd_en) begin
            r_rd <= r_mem[i_ctl.rd_idx];
        end
    end

    assign w_s = {1'b0, r_w};

    // Weight product, rounding, coordinate products, accumulation
    always_ff @(posedge i_clk) begin
        r_wprod <= {{PAR_W{1'b0}}, i_bu} * {{PAR_W{1'b0}}, i_bv};
        r_w     <= q_round(r_wprod);
        r_pt    <= r_rd;
        r_px    <= PROD_W'(r_pt.x) * PROD_W'(w_s);
        r_py    <= PROD_W'(r_pt.y) * PROD_W'(w_s);
        r_pz    <= PROD_W'(r_pt.z) * PROD_W'(w_s);
        if (i_ctl.clear) begin
            r_ax <= '0;
            r_ay <= '0;
            r_az <= '0;
        end else if (r_v3) begin
            r_ax <= r_ax + ACC_W'(r_px);
            r_ay <= r_ay + ACC_W'(r_py);
            r_az <= r_az + ACC_W'(r_pz);
        end
    end

    // Pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.rd_en;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Final rounding and saturation
    always_comb begin
        sx        = round_sat(r_ax);
        sy        = round_sat(r_ay);
        sz        = round_sat(r_az);
        o_res.x   = sx[COORD_W-1:0];
        o_res.y   = sy[COORD_W-1:0];
        o_res.z   = sz[COORD_W-1:0];
        o_res.ovf = sx[COORD_W] | sy[COORD_W] | sz[COORD_W];
    end

    // Accumulators are never cleared with products still in flight
    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clear |-> !(r_v1 || r_v2 || r_v3))
        else $error("accumulator clear with MAC pipeline busy");

    // Loads never overlap an evaluation pass
    a_wr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en |-> !(i_ctl.rd_en || r_v1 || r_v2 || r_v3))
        else $error("store write during evaluation");

    // Read address stays inside the grid
    a_rd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.rd_en |-> (32'(i_ctl.rd_idx) < NPTS))
        else $error("store read beyond grid");

endmodule

// ===== design/bezier_surface_point_eval_unit.sv =====
`timescale 1ns / 1ps
// Top level of the bicubic Bezier surface point evaluator.
//
// Usage: one valid/ready input channel (i_in) and one valid/ready output
// channel (o_out). A load transaction (action 0) writes one control point
// (x, y, z in signed Q16.16) into the 4x4 grid store; it gives no output.
// An evaluate transaction (action 1) takes u and v in unsigned Q1.16
// (values above 1.0 clamp to 1.0) and gives one surface point with a
// saturation flag. Load the whole grid before evaluating.
// An evaluate runs 3 power steps and 4 basis product steps in the basis
// unit, then one store read and multiply-accumulate per control point
// (16), then the MAC pipeline drains and the sum is rounded and saturated
// into the output register. The single store read port feeds one shared
// weight and MAC pass per control point. The input is taken again once
// the result sits in the output register, so a new evaluate is accepted
// only after the previous one is through.
// Reset (synchronous, active low) clears control state; store contents stay
// undefined until loaded. While the receiver stalls, the held result stays
// stable; a following evaluate finishes and then waits until it is free.
module bezier_surface_point_eval_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bsp_in_if.sink     i_in,
    bsp_out_if.source  o_out
);
    import bsp_pkg::*;

    t_state                  r_state;
    t_state                  n_state;
    logic [CNT_W-1:0]        r_cnt;
    logic [IDX_W-1:0]        r_idx;
    t_kidx                   r_row;
    t_kidx                   r_col;
    logic                    r_ovalid;
    t_result                 r_res;
    logic                    in_rdy;
    logic                    in_acc;
    logic                    eval_acc;
    logic                    out_free;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_idx;
    t_point                  wr_pt;
    t_bas_ctl                bas_ctl;
    t_mac_ctl                mac_ctl;
    logic [1:0][PAR_W-1:0]   bas_par;
    logic [1:0][K_W-1:0]     bas_sel;
    logic [1:0][PAR_W-1:0]   bas_out;
    t_result                 mac_res;

    function automatic logic [PAR_W-1:0] clamp_par(input logic [PAR_W-1:0] p);
        return (p > Q_ONE) ? Q_ONE : p;
    endfunction

    // Handshake
    assign in_rdy   = (r_state == ST_IDLE);
    assign in_acc   = i_in.valid && in_rdy;
    assign eval_acc = in_acc && (i_in.action == ACT_EVAL);
    assign out_free = !r_ovalid || o_out.ready;
    assign i_in.ready = in_rdy;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (eval_acc) n_state = ST_POW;
            ST_POW:   if (r_cnt == CNT_W'(MAX_DEG)) n_state = ST_PROD;
            ST_PROD:  if (r_cnt == CNT_W'(MAX_DEG)) n_state = ST_MAC;
            ST_MAC:   if (r_idx == IDX_W'(NPTS - 1)) n_state = ST_DRAIN;
            ST_DRAIN: if (r_cnt == CNT_W'(MAC_LAT - 1)) n_state = ST_OUT;
            ST_OUT:   if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control outputs for the basis unit, the store and the MAC pipeline
    always_comb begin
        wr_en = in_acc && (i_in.action == ACT_LOAD) &&
                (32'(i_in.point_row) < GRID_ROWS) && (32'(i_in.point_col) < GRID_COLS);
        wr_idx = IDX_W'(32'(i_in.point_row) * GRID_COLS + 32'(i_in.point_col));
        wr_pt.x = i_in.coord_x;
        wr_pt.y = i_in.coord_y;
        wr_pt.z = i_in.coord_z;

        bas_ctl.init    = eval_acc;
        bas_ctl.pow_en  = (r_state == ST_POW);
        bas_ctl.pow_k   = r_cnt[K_W-1:0];
        bas_ctl.prod_en = (r_state == ST_PROD);
        bas_ctl.prod_k  = r_cnt[K_W-1:0];
        bas_par[0]      = clamp_par(i_in.u_param);
        bas_par[1]      = clamp_par(i_in.v_param);
        bas_sel[0]      = r_row;
        bas_sel[1]      = r_col;

        mac_ctl.clear  = eval_acc;
        mac_ctl.rd_en  = (r_state == ST_MAC);
        mac_ctl.rd_idx = r_idx;
    end

    // State, step counter and grid walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_row   <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    if (eval_acc) begin
                        r_cnt <= CNT_W'(1);
                        r_idx <= '0;
                        r_row <= '0;
                        r_col <= '0;
                    end
                end
                ST_POW, ST_PROD: begin
                    r_cnt <= (r_cnt == CNT_W'(MAX_DEG)) ? '0 : r_cnt + CNT_W'(1);
                end
                ST_MAC: begin
                    r_idx <= r_idx + IDX_W'(1);
                    if (r_col == K_W'(GRID_COLS - 1)) begin
                        r_col <= '0;
                        r_row <= r_row + K_W'(1);
                    end else begin
                        r_col <= r_col + K_W'(1);
                    end
                    r_cnt <= '0;
                end
                ST_DRAIN: r_cnt <= r_cnt + CNT_W'(1);
                ST_OUT:   r_cnt <= '0;
                default:  r_cnt <= '0;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((r_state == ST_OUT) && out_free) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_OUT) && out_free) begin
            r_res <= mac_res;
        end
    end

    assign o_out.valid    = r_ovalid;
    assign o_out.surf_x   = r_res.x;
    assign o_out.surf_y   = r_res.y;
    assign o_out.surf_z   = r_res.z;
    assign o_out.overflow = r_res.ovf;

    // Basis powers and products for u and v
    bsp_basis u_basis (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (bas_ctl),
        .i_par   (bas_par),
        .i_sel   (bas_sel),
        .o_basis (bas_out)
    );

    // Store and multiply-accumulate pass
    bsp_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (wr_en),
        .i_wr_idx (wr_idx),
        .i_wr_pt  (wr_pt),
        .i_ctl    (mac_ctl),
        .i_bu     (bas_out[0]),
        .i_bv     (bas_out[1]),
        .o_res    (mac_res)
    );

    // A new result only comes out of the final rounding step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_state) == ST_OUT))
        else $error("result register loaded outside final step");

    // Grid walk: linear index matches row and column
    a_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAC) |->
            (32'(r_idx) == 32'(r_row) * GRID_COLS + 32'(r_col)))
        else $error("grid walk index mismatch");

    // The MAC pass starts only after the basis products
    a_mac_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAC) |->
            ($past(r_state) == ST_MAC || $past(r_state) == ST_PROD))
        else $error("MAC pass entered without basis");

endmodule

// ===== tb/sv/bezier_surface_point_eval_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the bicubic Bezier surface point evaluator.
module bezier_surface_point_eval_unit_tb;
    import bsp_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RAND_ITEMS   = 1100;
    localparam int DRAIN_CYCLES = 60;
    localparam int Q16_ONE      = 65536;

    typedef enum int {
        GRID_MIXED,
        GRID_MAX,
        GRID_MIN,
        GRID_SMALL
    } t_grid_mode;

    // One stimulus row: payload plus an optional typed-in result
    typedef struct {
        t_action                   act;
        logic [ROW_W-1:0]          row;
        logic [COL_W-1:0]          col;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [PAR_W-1:0]          u;
        logic [PAR_W-1:0]          v;
        bit                        typed;
        t_result                   res;
    } t_stim;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bsp_in_if  in_if ();
    bsp_out_if out_if ();

    bezier_surface_point_eval_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Testbench copy of the control point grid
    t_point  ctrl_grid [NPTS];
    t_result surf_pts_q [$];
    t_stim   dir_tab [$];

    int  err_count;
    int  cycle_cnt;
    int  n_items;
    int  n_loads;
    int  n_evals;
    int  n_clamped;
    int  n_results;
    int  n_saturated;
    int  rx_hold;
    bit  idle_off;

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
                     surf_pts_q.size());
            $display("bezier_surface_point_eval_unit test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Q1.16 power with rounding after each step
    function automatic longint unsigned q16_pow(longint unsigned b, int e);
        longint unsigned p;
        p = Q16_ONE;
        for (int k = 0; k < e; k++) begin
            p = (p * b + 32768) >> 16;
        end
        return p;
    endfunction

    function automatic longint unsigned binom_coef(int n, int k);
        longint unsigned c;
        c = 1;
        for (int j = 0; j < k; j++) begin
            c = c * longint'(n - j) / longint'(j + 1);
        end
        return c;
    endfunction

    function automatic longint unsigned bern_q16(int n, int k, longint unsigned t);
        longint unsigned prod;
        prod = binom_coef(n, k) * q16_pow(t, k) * q16_pow(Q16_ONE - t, n - k);
        return (prod + 32768) >> 16;
    endfunction

    // Round Q32.32 sum back to Q16.16 and clip to the signed 32-bit range
    function automatic logic signed [COORD_W-1:0] sat_q16(longint signed acc,
                                                          inout bit ovf);
        longint signed q;
        q = (acc + 64'sd32768) >>> 16;
        if (q > 64'sd2147483647) begin
            ovf = 1'b1;
            q   = 64'sd2147483647;
        end else if (q < -64'sd2147483648) begin
            ovf = 1'b1;
            q   = -64'sd2147483648;
        end
        return q[COORD_W-1:0];
    endfunction

    function automatic t_result eval_surface(logic [PAR_W-1:0] u_in,
                                             logic [PAR_W-1:0] v_in);
        longint unsigned tu, tv;
        longint unsigned bu [GRID_ROWS];
        longint unsigned bv [GRID_COLS];
        longint signed   ax, ay, az, w;
        int              idx;
        bit              ovf;
        t_result         r;
        tu = (u_in > Q_ONE) ? Q16_ONE : longint'(u_in);
        tv = (v_in > Q_ONE) ? Q16_ONE : longint'(v_in);
        for (int i = 0; i < GRID_ROWS; i++) bu[i] = bern_q16(GRID_ROWS - 1, i, tu);
        for (int j = 0; j < GRID_COLS; j++) bv[j] = bern_q16(GRID_COLS - 1, j, tv);
        ax = 0;
        ay = 0;
        az = 0;
        for (int i = 0; i < GRID_ROWS; i++) begin
            for (int j = 0; j < GRID_COLS; j++) begin
                w   = longint'((bu[i] * bv[j] + 32768) >> 16);
                idx = i * GRID_COLS + j;
                ax += longint'(ctrl_grid[idx].x) * w;
                ay += longint'(ctrl_grid[idx].y) * w;
                az += longint'(ctrl_grid[idx].z) * w;
            end
        end
        ovf   = 1'b0;
        r.x   = sat_q16(ax, ovf);
        r.y   = sat_q16(ay, ovf);
        r.z   = sat_q16(az, ovf);
        r.ovf = ovf;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [PAR_W-1:0] pick_param();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)  return '0;
        if (r < 16) return Q_ONE;
        if (r < 26) return PAR_W'($urandom_range(Q16_ONE + 1, (1 << PAR_W) - 1));
        return PAR_W'($urandom_range(0, Q16_ONE));
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_coord(t_grid_mode mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            GRID_MAX: begin
                return (r < 90) ? 32'sh7FFF_FFFF : $urandom;
            end
            GRID_MIN: begin
                return (r < 90) ? 32'sh8000_0000 : $urandom;
            end
            GRID_SMALL: begin
                return int'($urandom_range(0, 1 << 21)) - (1 << 20);
            end
            default: begin
                if (r < 10) return 32'sh7FFF_FFFF;
                if (r < 20) return 32'sh8000_0000;
                if (r < 50) return int'($urandom_range(0, 1 << 21)) - (1 << 20);
                return $urandom;
            end
        endcase
    endfunction

    function automatic t_stim stim_load(int idx, t_point p, logic [PAR_W-1:0] junk);
        t_stim s;
        s       = '{act: ACT_LOAD, default: '0};
        s.row   = ROW_W'(idx / GRID_COLS);
        s.col   = COL_W'(idx % GRID_COLS);
        s.x     = p.x;
        s.y     = p.y;
        s.z     = p.z;
        s.u     = junk;
        s.v     = ~junk;
        s.typed = 1'b0;
        return s;
    endfunction

    function automatic t_stim stim_eval(logic [PAR_W-1:0] u, logic [PAR_W-1:0] v);
        t_stim s;
        s       = '{act: ACT_EVAL, default: '0};
        s.u     = u;
        s.v     = v;
        s.typed = 1'b0;
        return s;
    endfunction

    // Evaluate with a result known in advance: a grid corner, no saturation
    function automatic t_stim stim_eval_at(logic [PAR_W-1:0] u, logic [PAR_W-1:0] v,
                                           t_point p);
        t_stim s;
        s       = stim_eval(u, v);
        s.typed = 1'b1;
        s.res   = '{x: p.x, y: p.y, z: p.z, ovf: 1'b0};
        return s;
    endfunction

    // Append one row to the directed table
    task automatic add_row(input t_stim s);
        dir_tab.insert(dir_tab.size(), s);
    endtask

    // Drive one transaction and wait for it to be taken
    task automatic send_txn(input t_stim s);
        int      gap;
        t_result exp_pt;
        gap = idle_off ? 0 : pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_if.action    <= s.act;
        in_if.point_row <= s.row;
        in_if.point_col <= s.col;
        in_if.coord_x   <= s.x;
        in_if.coord_y   <= s.y;
        in_if.coord_z   <= s.z;
        in_if.u_param   <= s.u;
        in_if.v_param   <= s.v;
        in_if.valid     <= 1'b1;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        n_items++;
        if (s.act == ACT_LOAD) begin
            ctrl_grid[s.row * GRID_COLS + s.col] = '{x: s.x, y: s.y, z: s.z};
            n_loads++;
        end else begin
            if (s.u > Q_ONE || s.v > Q_ONE) n_clamped++;
            exp_pt = s.typed ? s.res : eval_surface(s.u, s.v);
            surf_pts_q.insert(surf_pts_q.size(), exp_pt);
            n_evals++;
        end
    endtask

    // Drop valid and hold off until every pending surface point has arrived
    task automatic pause_until_drained();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (surf_pts_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        $display("ERROR @%0t result %0d %s: got %h expected %h", $realtime, n_results,
                 what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Result side: random backpressure and checking
    // ------------------------------------------------------------------

    initial out_if.ready = 1'b0;

    always @(negedge i_clk) begin
        int gap;
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
        end else if (idle_off || !i_rst_n) begin
            out_if.ready <= i_rst_n;
        end else begin
            gap = pick_gap();
            out_if.ready <= (gap == 0);
            rx_hold      <= (gap == 0) ? 0 : gap - 1;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (surf_pts_q.size() == 0) begin
                report_mismatch("unexpected transaction, x", out_if.surf_x, 'x);
            end else begin
                want = surf_pts_q.pop_front();
                if (out_if.surf_x !== want.x) report_mismatch("surf_x", out_if.surf_x, want.x);
                if (out_if.surf_y !== want.y) report_mismatch("surf_y", out_if.surf_y, want.y);
                if (out_if.surf_z !== want.z) report_mismatch("surf_z", out_if.surf_z, want.z);
                if (out_if.overflow !== want.ovf)
                    report_mismatch("overflow", 32'(out_if.overflow), 32'(want.ovf));
                if (want.ovf) n_saturated++;
            end
            n_results++;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        t_point     c00, c03, c30, c33, p;
        t_stim      s;
        t_grid_mode mode;
        int         n_phase, r, idx, n_phases;

        in_if.valid     = 1'b0;
        in_if.action    = ACT_LOAD;
        in_if.point_row = '0;
        in_if.point_col = '0;
        in_if.coord_x   = '0;
        in_if.coord_y   = '0;
        in_if.coord_z   = '0;
        in_if.u_param   = '0;
        in_if.v_param   = '0;
        i_rst_n         = 1'b0;
        idle_off        = 1'b0;
        n_phases        = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: full grid with extreme corners, then corner, clamp and midpoint evals and a corner overwrite
        c00 = '{x: 32'sh7FFF_FFFF, y: 32'sh8000_0000, z: 32'sh0000_0000};
        c03 = '{x: 32'sh8000_0000, y: 32'sh7FFF_FFFF, z: 32'sh0000_0001};
        c30 = '{x: 32'sh0001_0000, y: -32'sh0001_0000, z: 32'sh7FFF_FFFF};
        c33 = '{x: -32'sh1, y: 32'sh1, z: 32'sh8000_0000};
        for (int i = 0; i < NPTS; i++) begin
            p = '{x: (i << 16), y: -(i << 16), z: 32'sh1234_5678 ^ i};
            if (i == 0)                   p = c00;
            if (i == GRID_COLS - 1)       p = c03;
            if (i == NPTS - GRID_COLS)    p = c30;
            if (i == NPTS - 1)            p = c33;
            // parameters on a load are don't-care
            add_row(stim_load(i, p, (i == 5) ? {PAR_W{1'b1}} : PAR_W'(i * 8191)));
        end
        add_row(stim_eval_at('0, '0, c00));
        add_row(stim_eval_at(Q_ONE, Q_ONE, c33));
        add_row(stim_eval_at('0, Q_ONE, c03));
        add_row(stim_eval_at(Q_ONE, '0, c30));
        // parameters above one clamp to one
        add_row(stim_eval_at({PAR_W{1'b1}}, {PAR_W{1'b1}}, c33));
        // load fields on an evaluate are don't-care
        s     = stim_eval_at('0, '0, c00);
        s.row = '1;
        s.col = '1;
        s.x   = 32'sh7FFF_FFFF;
        s.y   = 32'sh8000_0000;
        s.z   = -32'sh1;
        add_row(s);
        add_row(stim_eval(PAR_W'(32768), PAR_W'(32768)));
        add_row(stim_eval(PAR_W'(16'hFFFF), PAR_W'(1)));
        // overwrite one corner and read it back
        c00 = '{x: 32'sh8000_0000, y: 32'sh7FFF_FFFF, z: 32'shFFFF_0000};
        add_row(stim_load(0, c00, Q_ONE));
        add_row(stim_eval_at('0, '0, c00));

        foreach (dir_tab[i]) send_txn(dir_tab[i]);
        pause_until_drained();

        // Random phases: reload the whole grid, then mostly evaluates with junk fields
        while (n_items < RAND_ITEMS + dir_tab.size()) begin
            r        = $urandom_range(0, 5);
            mode     = (r == 3) ? GRID_MAX : (r == 4) ? GRID_MIN :
                       (r == 5) ? GRID_SMALL : GRID_MIXED;
            idle_off = ($urandom_range(0, 4) == 0);
            for (int i = 0; i < NPTS; i++) begin
                p = '{x: pick_coord(mode), y: pick_coord(mode), z: pick_coord(mode)};
                send_txn(stim_load(i, p, PAR_W'($urandom)));
            end
            n_phase = $urandom_range(30, 70);
            for (int k = 0; k < n_phase; k++) begin
                r = $urandom_range(0, 99);
                if (r < 75) begin
                    s     = stim_eval(pick_param(), pick_param());
                    s.row = ROW_W'($urandom);
                    s.col = COL_W'($urandom);
                    s.x   = $urandom;
                    s.y   = $urandom;
                    s.z   = $urandom;
                end else begin
                    idx = $urandom_range(0, NPTS - 1);
                    p   = '{x: pick_coord(mode), y: pick_coord(mode), z: pick_coord(mode)};
                    s   = stim_load(idx, p, PAR_W'($urandom));
                end
                send_txn(s);
            end
            pause_until_drained();
            n_phases++;
        end

        idle_off = 1'b0;
        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d transactions over %0d random phases: %0d loads, %0d evaluates",
                 n_items, n_phases, n_loads, n_evals);
        $display("clamped parameters %0d, saturated results %0d, %0d results checked",
                 n_clamped, n_saturated, n_results);
        if (err_count == 0 && surf_pts_q.size() == 0) begin
            $display("bezier_surface_point_eval_unit test passed");
        end else begin
            $display("bezier_surface_point_eval_unit test failed");
        end
        $finish;
    end

endmodule
